// ===== design/normal_map_diffuse_shader_assert.svh =====
// Assertion macros for the shader modules; only nmd_div includes them.
`ifndef NORMAL_MAP_DIFFUSE_SHADER_ASSERT_SVH
`define NORMAL_MAP_DIFFUSE_SHADER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define NMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define NMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/nmd_pkg.sv =====
// Shared types, constants and arithmetic step functions of the normal-map shader.
`default_nettype none
package nmd_pkg;

    localparam int TEXEL_BITS = 8;
    localparam int TEXEL_MAX  = (1 << TEXEL_BITS) - 1;

    localparam int IN_BITS   = 104;
    localparam int OUT_BITS  = 32;

    localparam int SQL_STEPS = 31;  // root bits of |l|
    localparam int SQN_STEPS = 23;  // root bits of |n|
    localparam int QD_STEPS  = 22;  // quotient bits of d / |n|
    localparam int AD_STEPS  = 17;  // quotient bits of the cosine

    localparam logic [16:0] ANGLE_ONE = 17'h10000;

    localparam logic [2:0] REG_LIGHT_R = 3'd0;
    localparam logic [2:0] REG_LIGHT_G = 3'd1;
    localparam logic [2:0] REG_LIGHT_B = 3'd2;
    localparam logic [2:0] REG_AMB_R   = 3'd3;
    localparam logic [2:0] REG_AMB_G   = 3'd4;
    localparam logic [2:0] REG_AMB_B   = 3'd5;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pix;

    typedef struct packed {
        logic [9:0] light_r;
        logic [9:0] light_g;
        logic [9:0] light_b;
        logic [9:0] amb_r;
        logic [9:0] amb_g;
        logic [9:0] amb_b;
    } t_cfg;

    typedef struct packed {
        t_pix               pix;
        logic [17:0]        n2;
        logic [31:0]        l2;
        logic signed [25:0] d;
    } t_front;

    typedef struct packed {
        t_pix               pix;
        logic signed [25:0] d;
        logic [22:0]        un;
        logic [30:0]        ul;
    } t_root;

    typedef struct packed {
        logic [33:0] rem;
        logic [30:0] root;
    } t_sqs;

    typedef struct packed {
        logic [31:0] rem;
        logic        qb;
    } t_dvs;

    // One restoring square-root step: bring in two radicand bits.
    function automatic t_sqs sqrt_step(input logic [33:0] rem, input logic [30:0] root,
                                       input logic [1:0] pr);
        logic [33:0] sh;
        logic [33:0] tr;
        t_sqs        r;
        sh = {rem[31:0], pr};
        tr = {1'b0, root, 2'b01};
        if (sh >= tr) begin
            r.rem  = sh - tr;
            r.root = {root[29:0], 1'b1};
        end else begin
            r.rem  = sh;
            r.root = {root[29:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring division step: bring in one dividend bit.
    function automatic t_dvs div_step(input logic [31:0] rem, input logic b,
                                      input logic [31:0] dv);
        logic [31:0] sh;
        t_dvs        r;
        sh = {rem[30:0], b};
        if (sh >= dv) begin
            r.rem = sh - dv;
            r.qb  = 1'b1;
        end else begin
            r.rem = sh;
            r.qb  = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/nmd_front.sv =====
// Front stages: decode the normal, square and dot products, sums.
`default_nettype none
module nmd_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [nmd_pkg::IN_BITS-1:0] i_data,
    output logic                     o_valid,
    output nmd_pkg::t_front          o_data
);
    import nmd_pkg::*;

    logic               r0_valid, r1_valid, r2_valid;
    t_pix               r0_pix, r1_pix;
    logic signed [9:0]  r0_n [3];
    logic signed [15:0] r0_l [3];
    logic [16:0]        r1_nn [3];
    logic [30:0]        r1_ll [3];
    logic signed [25:0] r1_nl [3];
    t_front             r2_data;

    logic signed [19:0] w_nn [3];
    logic signed [31:0] w_ll [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_axis
        assign w_nn[c] = r0_n[c] * r0_n[c];
        assign w_ll[c] = r0_l[c] * r0_l[c];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // 2t - M, always odd
                r0_n[c]  <= $signed({1'b0, i_data[32+8*c +: 8], 1'b0}) - 10'(TEXEL_MAX);
                r0_l[c]  <= $signed(i_data[56+16*c +: 16]);
                r1_nn[c] <= w_nn[c][16:0];
                r1_ll[c] <= w_ll[c][30:0];
                r1_nl[c] <= 26'(r0_n[c]) * 26'(r0_l[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_pix      <= {i_data[7:0], i_data[15:8], i_data[23:16], i_data[31:24]};
            r1_pix      <= r0_pix;
            r2_data.pix <= r1_pix;
            r2_data.n2  <= 18'(r1_nn[0]) + 18'(r1_nn[1]) + 18'(r1_nn[2]);
            r2_data.l2  <= 32'(r1_ll[0]) + 32'(r1_ll[1]) + 32'(r1_ll[2]);
            r2_data.d   <= r1_nl[0] + r1_nl[1] + r1_nl[2];
        end
    end

    assign o_valid = r2_valid;
    assign o_data  = r2_data;
endmodule
`default_nettype wire

// ===== design/nmd_sqrt.sv =====
// Bit-per-stage square roots of the normal and light lengths.
`default_nettype none
module nmd_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  nmd_pkg::t_front i_data,
    output logic            o_valid,
    output nmd_pkg::t_root  o_data
);
    import nmd_pkg::*;

    typedef struct packed {
        t_pix               pix;
        logic signed [25:0] d;
        logic [17:0]        n2;
        logic [31:0]        l2;
        logic [33:0]        n_rem;
        logic [30:0]        n_root;
        logic [33:0]        l_rem;
        logic [30:0]        l_root;
    } t_sq;

    logic r_valid [SQL_STEPS];
    t_sq  r_st    [SQL_STEPS];

    for (genvar k = 0; k < SQL_STEPS; k++) begin : g_stage
        logic       w_vin;
        t_sq        w_in;
        t_sq        n_st;
        logic [1:0] w_pn, w_pl;
        t_sqs       w_sn, w_sl;

        if (k == 0) begin : g_first
            assign w_vin = i_valid;
            always_comb begin
                w_in     = '0;
                w_in.pix = i_data.pix;
                w_in.d   = i_data.d;
                w_in.n2  = i_data.n2;
                w_in.l2  = i_data.l2;
            end
        end else begin : g_next
            assign w_vin = r_valid[k-1];
            assign w_in  = r_st[k-1];
        end

        // radicands are n2 << 28 and l2 << 30: low pairs are zero
        if (k < 9) begin : g_pn
            assign w_pn = w_in.n2[17-2*k -: 2];
        end else begin : g_pn0
            assign w_pn = 2'b00;
        end
        if (k < 16) begin : g_pl
            assign w_pl = w_in.l2[31-2*k -: 2];
        end else begin : g_pl0
            assign w_pl = 2'b00;
        end

        assign w_sn = sqrt_step(w_in.n_rem, w_in.n_root, w_pn);
        assign w_sl = sqrt_step(w_in.l_rem, w_in.l_root, w_pl);

        always_comb begin
            n_st        = w_in;
            n_st.l_rem  = w_sl.rem;
            n_st.l_root = w_sl.root;
            if (k < SQN_STEPS) begin
                n_st.n_rem  = w_sn.rem;
                n_st.n_root = w_sn.root;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid    = r_valid[SQL_STEPS-1];
    assign o_data.pix = r_st[SQL_STEPS-1].pix;
    assign o_data.d   = r_st[SQL_STEPS-1].d;
    assign o_data.un  = r_st[SQL_STEPS-1].n_root[22:0];
    assign o_data.ul  = r_st[SQL_STEPS-1].l_root;
endmodule
`default_nettype wire

// ===== design/nmd_div.sv =====
// Bit-per-stage dividers that turn the dot product into a clamped cosine.
`default_nettype none
`include "normal_map_diffuse_shader_assert.svh"
module nmd_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  nmd_pkg::t_root i_data,
    output logic           o_valid,
    output nmd_pkg::t_pix  o_pix,
    output logic [16:0]    o_angle
);
    import nmd_pkg::*;

    typedef struct packed {
        t_pix        pix;
        logic        hit;
        logic [1:0]  dlo;
        logic [31:0] rem;
        logic [21:0] q;
        logic [22:0] un;
        logic [30:0] ul;
    } t_qd;

    typedef struct packed {
        t_pix        pix;
        logic        hit;
        logic        ovf;
        logic [31:0] rem;
        logic [16:0] a;
        logic [30:0] ul;
    } t_ad;

    logic r_qv [QD_STEPS];
    t_qd  r_qs [QD_STEPS];
    logic r_av [AD_STEPS+1];
    t_ad  r_as [AD_STEPS+1];

    // q = (d << 20) / un, at most 22 bits: start from d >> 2
    for (genvar j = 0; j < QD_STEPS; j++) begin : g_qstage
        logic w_vin;
        t_qd  w_in;
        t_qd  n_st;
        logic w_b;
        t_dvs w_s;

        if (j == 0) begin : g_first
            assign w_vin = i_valid;
            always_comb begin
                w_in     = '0;
                w_in.pix = i_data.pix;
                w_in.hit = (i_data.d > 26'sd0) && (i_data.ul != '0);
                w_in.dlo = i_data.d[1:0];
                w_in.rem = {8'b0, i_data.d[25:2]};
                w_in.un  = i_data.un;
                w_in.ul  = i_data.ul;
            end
        end else begin : g_next
            assign w_vin = r_qv[j-1];
            assign w_in  = r_qs[j-1];
        end

        if (j == 0) begin : g_b1
            assign w_b = w_in.dlo[1];
        end else if (j == 1) begin : g_b0
            assign w_b = w_in.dlo[0];
        end else begin : g_bz
            assign w_b = 1'b0;
        end

        assign w_s = div_step(w_in.rem, w_b, {9'b0, w_in.un});

        always_comb begin
            n_st     = w_in;
            n_st.rem = w_s.rem;
            n_st.q   = {w_in.q[20:0], w_s.qb};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[j] <= 1'b0;
            end else if (i_en) begin
                r_qv[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qs[j] <= n_st;
            end
        end
    end

    // angle = (q << 25) / ul: overflow test first, then 17 quotient bits
    for (genvar j = 0; j <= AD_STEPS; j++) begin : g_astage
        logic w_vin;
        t_ad  n_st;

        if (j == 0) begin : g_first
            assign w_vin = r_qv[QD_STEPS-1];
            always_comb begin
                n_st     = '0;
                n_st.pix = r_qs[QD_STEPS-1].pix;
                n_st.hit = r_qs[QD_STEPS-1].hit;
                n_st.ul  = r_qs[QD_STEPS-1].ul;
                n_st.ovf = {1'b0, r_qs[QD_STEPS-1].q, 8'b0} >= r_qs[QD_STEPS-1].ul;
                n_st.rem = {2'b0, r_qs[QD_STEPS-1].q, 8'b0};
            end
        end else begin : g_next
            t_dvs w_s;
            assign w_vin = r_av[j-1];
            assign w_s   = div_step(r_as[j-1].rem, 1'b0, {1'b0, r_as[j-1].ul});
            always_comb begin
                n_st     = r_as[j-1];
                n_st.rem = w_s.rem;
                n_st.a   = {r_as[j-1].a[15:0], w_s.qb};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
            end else if (i_en) begin
                r_av[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_as[j] <= n_st;
            end
        end
    end

    always_comb begin
        priority if (!r_as[AD_STEPS].hit) begin
            o_angle = '0;
        end else if (r_as[AD_STEPS].ovf || r_as[AD_STEPS].a[16]) begin
            o_angle = ANGLE_ONE;
        end else begin
            o_angle = r_as[AD_STEPS].a;
        end
    end

    assign o_valid = r_av[AD_STEPS];
    assign o_pix   = r_as[AD_STEPS].pix;

    `NMD_ASSERT_IMP(a_angle_max, o_valid, o_angle <= ANGLE_ONE, "cosine above one")
    `NMD_ASSERT_IMP(a_angle_miss, o_valid && !r_as[AD_STEPS].hit, o_angle == '0,
                    "back-facing pixel has nonzero cosine")
    `NMD_ASSERT_NXT(a_stall_hold, o_valid && !i_en, o_valid, "stalled result dropped")
endmodule
`default_nettype wire

// ===== design/nmd_shade.sv =====
// Color stages: scale light by the cosine, add ambient, modulate the base texel.
`default_nettype none
module nmd_shade (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  nmd_pkg::t_pix i_pix,
    input  logic [16:0]   i_angle,
    input  nmd_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output nmd_pkg::t_pix o_pix
);
    import nmd_pkg::*;

    logic        ra_valid, rb_valid, rc_valid;
    t_pix        ra_pix, rb_pix;
    logic [26:0] ra_prod [3];
    logic [18:0] rb_prod [3];
    logic [7:0]  rc_ch   [3];
    logic [7:0]  rc_a;

    logic [9:0]  w_light [3];
    logic [9:0]  w_amb   [3];
    logic [7:0]  w_base  [3];

    assign w_light = '{i_cfg.light_r, i_cfg.light_g, i_cfg.light_b};
    assign w_amb   = '{i_cfg.amb_r, i_cfg.amb_g, i_cfg.amb_b};
    assign w_base  = '{ra_pix.r, ra_pix.g, ra_pix.b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
            rb_valid <= 1'b0;
            rc_valid <= 1'b0;
        end else if (i_en) begin
            ra_valid <= i_valid;
            rb_valid <= ra_valid;
            rc_valid <= rb_valid;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [10:0] w_f;
        logic [19:0] w_sum;
        assign w_f   = 11'(ra_prod[c][26:16]) + 11'(w_amb[c]);
        assign w_sum = 20'(rb_prod[c]) + 20'd128;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                ra_prod[c] <= 27'(i_angle) * 27'(w_light[c]);
                rb_prod[c] <= 19'(w_base[c]) * 19'(w_f);
                rc_ch[c]   <= (w_sum[19:8] > 12'd255) ? 8'd255 : w_sum[15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_pix <= i_pix;
            rb_pix <= ra_pix;
            rc_a   <= rb_pix.a;
        end
    end

    assign o_valid = rc_valid;
    assign o_pix   = '{r: rc_ch[0], g: rc_ch[1], b: rc_ch[2], a: rc_a};
endmodule
`default_nettype wire

// ===== design/normal_map_diffuse_shader.sv =====
// Top level of the tangent-space normal-map Lambert diffuse shader.
`default_nettype none
// One pixel per transfer: the base texel, a normal-map texel decoded as 2t-255 and an
// unnormalized signed Q2.13 light direction go in; the base color scaled by
// (cosine * light color + ambient color) comes out, saturated to 0..255, with alpha
// passed through. The cosine is dot(n,l) / (|n| |l|) in unsigned Q1.16, clamped to [0,1];
// a zero light direction or a back-facing light leaves only ambient. The block takes a
// new pixel every clock unless the pipeline is held, and has 3 front stages (decode,
// products, sums), 31 square-root stages (one root bit per stage, both lengths side by
// side), 22 + 18 divider stages (one quotient bit per stage, plus the overflow test),
// and 3 color stages, the last of which is the output register. The pipeline advances
// whenever the output register is empty or taken, so no pixel is taken while a result
// waits untaken. Light and ambient colors are unsigned Q2.8 registers (256 = 1.0) on a
// write channel that is always ready; write them only while no pixel is in flight.
// Indexes above five are ignored.
module normal_map_diffuse_shader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // base_red, base_green, base_blue, base_alpha, normal_tex_x, normal_tex_y,
    // normal_tex_z (8 bits each), light_dir_x, light_dir_y, light_dir_z (16 bits each)
    input  logic [nmd_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha (8 bits each)
    output logic [nmd_pkg::OUT_BITS-1:0] m_axis_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [9:0]                  i_cfg_data
);
    import nmd_pkg::*;

    t_cfg   r_cfg;
    logic   w_en;
    logic   w_f_valid, w_s_valid, w_d_valid;
    t_front w_front;
    t_root  w_root;
    t_pix   w_d_pix, w_o_pix;
    logic [16:0] w_angle;

    // the whole pipe moves together; hold it only while a result waits untaken
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_r <= 10'd256;
            r_cfg.light_g <= 10'd256;
            r_cfg.light_b <= 10'd256;
            r_cfg.amb_r   <= 10'd0;
            r_cfg.amb_g   <= 10'd0;
            r_cfg.amb_b   <= 10'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LIGHT_R: r_cfg.light_r <= i_cfg_data;
                REG_LIGHT_G: r_cfg.light_g <= i_cfg_data;
                REG_LIGHT_B: r_cfg.light_b <= i_cfg_data;
                REG_AMB_R:   r_cfg.amb_r   <= i_cfg_data;
                REG_AMB_G:   r_cfg.amb_g   <= i_cfg_data;
                REG_AMB_B:   r_cfg.amb_b   <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    nmd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid && w_en),
        .i_data  (s_axis_tdata),
        .o_valid (w_f_valid),
        .o_data  (w_front)
    );

    nmd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_data  (w_front),
        .o_valid (w_s_valid),
        .o_data  (w_root)
    );

    nmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_data  (w_root),
        .o_valid (w_d_valid),
        .o_pix   (w_d_pix),
        .o_angle (w_angle)
    );

    nmd_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_pix   (w_d_pix),
        .i_angle (w_angle),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .o_pix   (w_o_pix)
    );

    assign m_axis_tdata = {w_o_pix.a, w_o_pix.b, w_o_pix.g, w_o_pix.r};
endmodule
`default_nettype wire
